@@ src/assert_macros.svh @@
// Assertion macros shared by the flow averager RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define SDFA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition is followed by a property in the next cycle.
`define SDFA_ASSERT_NEXT(lbl, clk, rst_n, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);

`endif

@@ src/sdfa_pkg.sv @@
// Shared types and constants of the flow averager.
package sdfa_pkg;

    localparam int CFG_W      = 24;
    localparam int CFG_ADDR_W = 1;
    localparam int FLOW_W     = 41;
    localparam int COIL_W     = 32;
    localparam int ACTION_W   = 2;
    localparam int IN_USER_W  = 3;
    localparam int OUT_USER_W = 2;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_ZERO_OFFSET = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPAN_GAIN   = 1'b1;

    // Span gain of 1.0 in Q8.16
    localparam logic [CFG_W-1:0] SPAN_GAIN_RESET = 24'h010000;

    // Saturation limits of the latched flow
    localparam logic [FLOW_W-1:0] FLOW_MAX = {1'b0, {(FLOW_W-1){1'b1}}};
    localparam logic [FLOW_W-1:0] FLOW_MIN = {1'b1, {(FLOW_W-1){1'b0}}};

    typedef enum logic [ACTION_W-1:0] {
        ACT_SAMPLE  = 2'd0,
        ACT_COMPUTE = 2'd1,
        ACT_CLEAR   = 2'd2,
        ACT_NOP     = 2'd3
    } t_action;

    // Divider request and status
    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

@@ src/sync_detect_flow_averager_core.sv @@
// Top level of the synchronous-detection flow averager.
//
// Input channel s_axis_*: one beat per action. tuser carries the action
// (add sample, compute, clear, or no-op) and the coil polarity; tdata carries
// the electrode and coil-current samples. Output channel m_axis_*: exactly one
// beat per input beat, in order, with the latched flow, the latched mean coil
// current, the sample count and the flow-valid and window-full flags.
// Configuration: i_cfg_we writes i_cfg_wdata to register i_cfg_addr
// (0 zero offset, 1 span gain); write only while the block is idle.
// A sample, clear or no-op beat passes the front register and the queue; the
// back end takes it in S_IDLE, loads the output register from S_OUT and takes no
// new beat until it is back in S_IDLE. A compute beat with both halves filled
// runs the shared serial divider, one quotient bit per cycle, for the positive,
// negative and coil means; with one half empty it divides only the coil mean.
// Reset clears the sums, counts and latched results, sets the zero offset to 0
// and the span gain to 1.0. When the receiver stalls, the result waits in the
// output register, the back end holds, a two-entry queue and the front
// register fill up, and then s_axis_tready drops.
module sync_detect_flow_averager_core #(
    parameter int SAMPLE_BITS    = 24,
    parameter int COUNT_BITS     = 20,
    parameter int GAIN_FRAC_BITS = 16,
    parameter int OUT_FRAC_BITS  = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [sdfa_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input  logic [sdfa_pkg::CFG_W-1:0]            i_cfg_wdata,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // electrode, coil_sample
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,
    // action, polarity
    input  logic [sdfa_pkg::IN_USER_W-1:0]        s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // flow_signal, coil_mean, sample_count
    output logic [((sdfa_pkg::FLOW_W+sdfa_pkg::COIL_W+COUNT_BITS+7)/8)*8-1:0] m_axis_tdata,
    // flow_valid, window_full
    output logic [sdfa_pkg::OUT_USER_W-1:0]       m_axis_tuser
);

    import sdfa_pkg::*;

    localparam int CAL_W      = max_int(SAMPLE_BITS, CFG_W) + 1;
    localparam int CMD_W      = ACTION_W + 1 + SAMPLE_BITS + CAL_W;
    localparam int IN_DATA_W  = ((2*SAMPLE_BITS+7)/8)*8;
    localparam int OUT_DATA_W = ((FLOW_W+COIL_W+COUNT_BITS+7)/8)*8;

    logic [CFG_W-1:0] w_span_gain;
    logic             w_f_valid;
    logic             w_f_ready;
    logic [CMD_W-1:0] w_f_cmd;
    logic             w_q_valid;
    logic             w_q_ready;
    logic [CMD_W-1:0] w_q_cmd;

    sdfa_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .CAL_W       (CAL_W),
        .IN_DATA_W   (IN_DATA_W),
        .CMD_W       (CMD_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_tvalid    (s_axis_tvalid),
        .o_tready    (s_axis_tready),
        .i_tdata     (s_axis_tdata),
        .i_tuser     (s_axis_tuser),
        .o_span_gain (w_span_gain),
        .o_cmd_valid (w_f_valid),
        .i_cmd_ready (w_f_ready),
        .o_cmd       (w_f_cmd)
    );

    sdfa_queue #(
        .WIDTH (CMD_W),
        .DEPTH (2)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_data  (w_f_cmd),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_data  (w_q_cmd)
    );

    sdfa_back #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COUNT_BITS     (COUNT_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
        .OUT_FRAC_BITS  (OUT_FRAC_BITS),
        .CAL_W          (CAL_W),
        .CMD_W          (CMD_W),
        .OUT_DATA_W     (OUT_DATA_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_span_gain (w_span_gain),
        .i_cmd_valid (w_q_valid),
        .o_cmd_ready (w_q_ready),
        .i_cmd       (w_q_cmd),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_tdata     (m_axis_tdata),
        .o_tuser     (m_axis_tuser)
    );

endmodule

@@ src/sdfa_queue.sv @@
// Short command queue between the front end and the back end.
`include "assert_macros.svh"

module sdfa_queue #(
    parameter int WIDTH = 52,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);

    // DEPTH is a power of two so the pointers wrap by themselves
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    // Store an incoming beat
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `SDFA_ASSERT_NEXT(a_push_fills, i_clk, i_rst_n, w_push && !w_pop, r_count == $past(r_count) + 1'b1, "queue fill level did not rise on push")

endmodule

@@ src/sdfa_div.sv @@
// Serial restoring divider, one quotient bit per cycle.
`include "assert_macros.svh"

module sdfa_div #(
    parameter int NUM_W = 53,
    parameter int DEN_W = 20
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  sdfa_pkg::t_div_ctl       i_ctl,
    input  logic [NUM_W-1:0]         i_dividend,
    input  logic [DEN_W-1:0]         i_divisor,
    output sdfa_pkg::t_div_stat      o_stat,
    output logic [NUM_W-1:0]         o_quotient
);

    import sdfa_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W:0]   w_trial;
    logic             w_fits;
    logic [DEN_W:0]   w_diff;

    // Shift the next dividend bit into the partial remainder and try the subtract
    assign w_trial = {r_rem, r_quo[NUM_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_fits  = (w_trial >= {1'b0, r_den});

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

    // Sequence control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient datapath
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[NUM_W-2:0], w_fits};
            r_rem <= w_fits ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
        end
    end

    `SDFA_ASSERT(a_start_idle, i_clk, i_rst_n, i_ctl.start |-> !r_busy, "divider started while busy")

endmodule

@@ src/sdfa_front.sv @@
// Front end: configuration registers, input acceptance and action decode.
module sdfa_front #(
    parameter int SAMPLE_BITS = 24,
    parameter int CAL_W       = 25,
    parameter int IN_DATA_W   = 48,
    parameter int CMD_W       = 52
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sdfa_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [sdfa_pkg::CFG_W-1:0]        i_cfg_wdata,
    input  logic                              i_tvalid,
    output logic                              o_tready,
    input  logic [IN_DATA_W-1:0]              i_tdata,
    input  logic [sdfa_pkg::IN_USER_W-1:0]    i_tuser,
    output logic [sdfa_pkg::CFG_W-1:0]        o_span_gain,
    output logic                              o_cmd_valid,
    input  logic                              i_cmd_ready,
    output logic [CMD_W-1:0]                  o_cmd
);

    import sdfa_pkg::*;

    logic signed [CFG_W-1:0]       r_zero_offset;
    logic [CFG_W-1:0]              r_span_gain;
    logic                          r_cmd_valid;
    logic [CMD_W-1:0]              r_cmd;
    logic signed [SAMPLE_BITS-1:0] w_electrode;
    logic signed [SAMPLE_BITS-1:0] w_coil;
    logic signed [CAL_W-1:0]       w_cal;
    t_action                       w_act;
    logic                          w_pol;
    logic                          w_accept;

    // Unpack the beat and remove the electrode zero offset
    assign w_electrode = i_tdata[SAMPLE_BITS-1:0];
    assign w_coil      = i_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign w_act       = t_action'(i_tuser[ACTION_W-1:0]);
    assign w_pol       = i_tuser[ACTION_W];
    assign w_cal       = CAL_W'(w_electrode) - CAL_W'(r_zero_offset);

    assign o_tready    = !r_cmd_valid || i_cmd_ready;
    assign w_accept    = i_tvalid && o_tready;
    assign o_cmd_valid = r_cmd_valid;
    assign o_cmd       = r_cmd;
    assign o_span_gain = r_span_gain;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_offset <= '0;
            r_span_gain   <= SPAN_GAIN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_ZERO_OFFSET: r_zero_offset <= i_cfg_wdata;
                CFG_SPAN_GAIN:   r_span_gain   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Hold the decoded command until the queue takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_valid <= 1'b0;
        end else if (w_accept) begin
            r_cmd_valid <= 1'b1;
        end else if (i_cmd_ready) begin
            r_cmd_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= CMD_W'({w_act, w_pol, w_coil, w_cal});
        end
    end

endmodule

@@ src/sdfa_back.sv @@
// Back end: accumulators, compute sequencer and result register.
`include "assert_macros.svh"

module sdfa_back #(
    parameter int SAMPLE_BITS    = 24,
    parameter int COUNT_BITS     = 20,
    parameter int GAIN_FRAC_BITS = 16,
    parameter int OUT_FRAC_BITS  = 8,
    parameter int CAL_W          = 25,
    parameter int CMD_W          = 52,
    parameter int OUT_DATA_W     = 96
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [sdfa_pkg::CFG_W-1:0]        i_span_gain,
    input  logic                              i_cmd_valid,
    output logic                              o_cmd_ready,
    input  logic [CMD_W-1:0]                  i_cmd,
    output logic                              o_tvalid,
    input  logic                              i_tready,
    output logic [OUT_DATA_W-1:0]             o_tdata,
    output logic [sdfa_pkg::OUT_USER_W-1:0]   o_tuser
);

    import sdfa_pkg::*;

    localparam int SUMP_W = CAL_W + COUNT_BITS;
    localparam int SUMC_W = SAMPLE_BITS + COUNT_BITS;
    localparam int NUM_W  = SUMP_W + OUT_FRAC_BITS;
    localparam int MEAN_W = CAL_W + OUT_FRAC_BITS;
    localparam int MAG_W  = MEAN_W;
    localparam int LO_W   = (MAG_W + 1) / 2;
    localparam int HI_W   = MAG_W - LO_W;
    localparam int PROD_W = MAG_W + CFG_W;
    localparam int SHIFT  = GAIN_FRAC_BITS + 1;
    localparam int CS_W   = COUNT_BITS + 1;

    localparam logic [COUNT_BITS-1:0] CNT_MAX  = {COUNT_BITS{1'b1}};
    localparam logic [PROD_W-1:0]     POS_LIM  = (PROD_W'(1) << (FLOW_W - 1)) - PROD_W'(1);
    localparam logic [PROD_W-1:0]     NEG_LIM  = PROD_W'(1) << (FLOW_W - 1);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DIV_P  = 9'b000000010,
        S_DIV_N  = 9'b000000100,
        S_DIFF   = 9'b000001000,
        S_MUL_LO = 9'b000010000,
        S_MUL_HI = 9'b000100000,
        S_FLOW   = 9'b001000000,
        S_DIV_C  = 9'b010000000,
        S_OUT    = 9'b100000000
    } t_state;

    t_state                        r_state, n_state;
    logic signed [SUMP_W-1:0]      r_sum_pos, n_sum_pos;
    logic signed [SUMP_W-1:0]      r_sum_neg, n_sum_neg;
    logic signed [SUMC_W-1:0]      r_sum_coil, n_sum_coil;
    logic [COUNT_BITS-1:0]         r_cnt_pos, n_cnt_pos;
    logic [COUNT_BITS-1:0]         r_cnt_neg, n_cnt_neg;
    logic [COUNT_BITS-1:0]         r_cnt_all, n_cnt_all;
    logic [FLOW_W-1:0]             r_held_flow, n_held_flow;
    logic [COIL_W-1:0]             r_held_coil, n_held_coil;
    logic                          r_held_valid, n_held_valid;
    logic                          r_issued, n_issued;
    logic                          r_out_valid, n_out_valid;
    logic signed [MEAN_W-1:0]      r_mean_p, n_mean_p;
    logic signed [MEAN_W-1:0]      r_mean_n, n_mean_n;
    logic [MAG_W-1:0]              r_mag, n_mag;
    logic                          r_neg, n_neg;
    logic [PROD_W-1:0]             r_prod, n_prod;
    logic [OUT_DATA_W-1:0]         r_out_data, n_out_data;
    logic [OUT_USER_W-1:0]         r_out_user, n_out_user;

    logic signed [CAL_W-1:0]       w_cal;
    logic signed [SAMPLE_BITS-1:0] w_coil;
    logic                          w_pol;
    t_action                       w_act;
    logic signed [SUMP_W-1:0]      w_sel_sum;
    logic [COUNT_BITS-1:0]         w_sel_cnt;
    logic                          w_sel_neg;
    logic [SUMP_W-1:0]             w_sel_mag;
    logic [NUM_W-1:0]              w_dividend;
    logic [NUM_W-1:0]              w_quo;
    logic signed [NUM_W:0]         w_qs;
    t_div_ctl                      w_div_ctl;
    t_div_stat                     w_div_stat;
    logic                          w_in_div;
    logic signed [MEAN_W:0]        w_diff;
    logic [LO_W+CFG_W-1:0]         w_plo;
    logic [HI_W+CFG_W-1:0]         w_phi;
    logic [PROD_W-1:0]             w_shr;
    logic                          w_full;

    // Unpack the queued command
    assign w_cal  = i_cmd[CAL_W-1:0];
    assign w_coil = i_cmd[CAL_W +: SAMPLE_BITS];
    assign w_pol  = i_cmd[CAL_W + SAMPLE_BITS];
    assign w_act  = t_action'(i_cmd[CAL_W + SAMPLE_BITS + 1 +: ACTION_W]);

    assign o_cmd_ready = (r_state == S_IDLE);
    assign w_full      = (r_cnt_all == CNT_MAX);

    // Pick the sum and count for the running division
    always_comb begin
        if (r_state == S_DIV_P) begin
            w_sel_sum = r_sum_pos;
            w_sel_cnt = r_cnt_pos;
        end else if (r_state == S_DIV_N) begin
            w_sel_sum = r_sum_neg;
            w_sel_cnt = r_cnt_neg;
        end else begin
            w_sel_sum = SUMP_W'(r_sum_coil);
            w_sel_cnt = r_cnt_all;
        end
    end

    assign w_sel_neg  = w_sel_sum[SUMP_W-1];
    assign w_sel_mag  = w_sel_neg ? SUMP_W'(-w_sel_sum) : SUMP_W'(w_sel_sum);
    assign w_dividend = NUM_W'(w_sel_mag) << OUT_FRAC_BITS;
    assign w_qs       = w_sel_neg ? -$signed({1'b0, w_quo}) : $signed({1'b0, w_quo});

    assign w_in_div        = (r_state == S_DIV_P) || (r_state == S_DIV_N) || (r_state == S_DIV_C);
    assign w_div_ctl.start = w_in_div && !r_issued;

    sdfa_div #(
        .NUM_W (NUM_W),
        .DEN_W (COUNT_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_div_ctl),
        .i_dividend (w_dividend),
        .i_divisor  (w_sel_cnt),
        .o_stat     (w_div_stat),
        .o_quotient (w_quo)
    );

    // Flow datapath: difference, split multiply, scale
    assign w_diff = (MEAN_W+1)'(r_mean_p) - (MEAN_W+1)'(r_mean_n);
    assign w_plo  = r_mag[LO_W-1:0] * i_span_gain;
    assign w_phi  = r_mag[MAG_W-1:LO_W] * i_span_gain;
    assign w_shr  = r_prod >> SHIFT;

    // Sequencer and next-state values
    always_comb begin
        n_state      = r_state;
        n_sum_pos    = r_sum_pos;
        n_sum_neg    = r_sum_neg;
        n_sum_coil   = r_sum_coil;
        n_cnt_pos    = r_cnt_pos;
        n_cnt_neg    = r_cnt_neg;
        n_cnt_all    = r_cnt_all;
        n_held_flow  = r_held_flow;
        n_held_coil  = r_held_coil;
        n_held_valid = r_held_valid;
        n_issued     = r_issued;
        n_mean_p     = r_mean_p;
        n_mean_n     = r_mean_n;
        n_mag        = r_mag;
        n_neg        = r_neg;
        n_prod       = r_prod;
        n_out_data   = r_out_data;
        n_out_user   = r_out_user;
        n_out_valid  = r_out_valid && !i_tready;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = S_OUT;
                    unique case (w_act)
                        ACT_SAMPLE: begin
                            // Drop the sample once the window is full
                            if (!w_full) begin
                                if (w_pol) begin
                                    n_sum_pos = r_sum_pos + SUMP_W'(w_cal);
                                    n_cnt_pos = r_cnt_pos + 1'b1;
                                end else begin
                                    n_sum_neg = r_sum_neg + SUMP_W'(w_cal);
                                    n_cnt_neg = r_cnt_neg + 1'b1;
                                end
                                n_sum_coil = r_sum_coil + SUMC_W'(w_coil);
                                n_cnt_all  = r_cnt_all + 1'b1;
                            end
                        end
                        ACT_COMPUTE: begin
                            if (r_cnt_pos != '0 && r_cnt_neg != '0) begin
                                n_state = S_DIV_P;
                            end else begin
                                // Empty half: flow is zero and invalid
                                n_held_flow  = '0;
                                n_held_valid = 1'b0;
                                if (r_cnt_all != '0) begin
                                    n_state = S_DIV_C;
                                end else begin
                                    n_held_coil = '0;
                                end
                            end
                        end
                        ACT_CLEAR: begin
                            n_sum_pos  = '0;
                            n_sum_neg  = '0;
                            n_sum_coil = '0;
                            n_cnt_pos  = '0;
                            n_cnt_neg  = '0;
                            n_cnt_all  = '0;
                        end
                        ACT_NOP: ;
                    endcase
                end
            end
            S_DIV_P: begin
                if (!r_issued) begin
                    n_issued = 1'b1;
                end else if (w_div_stat.done) begin
                    n_issued = 1'b0;
                    n_mean_p = MEAN_W'(w_qs);
                    n_state  = S_DIV_N;
                end
            end
            S_DIV_N: begin
                if (!r_issued) begin
                    n_issued = 1'b1;
                end else if (w_div_stat.done) begin
                    n_issued = 1'b0;
                    n_mean_n = MEAN_W'(w_qs);
                    n_state  = S_DIFF;
                end
            end
            S_DIFF: begin
                n_neg   = w_diff[MEAN_W];
                n_mag   = w_diff[MEAN_W] ? MAG_W'(-w_diff) : MAG_W'(w_diff);
                n_state = S_MUL_LO;
            end
            S_MUL_LO: begin
                n_prod  = PROD_W'(w_plo);
                n_state = S_MUL_HI;
            end
            S_MUL_HI: begin
                n_prod  = r_prod + (PROD_W'(w_phi) << LO_W);
                n_state = S_FLOW;
            end
            S_FLOW: begin
                // Truncate the magnitude, then restore the sign and saturate
                if (!r_neg) begin
                    n_held_flow = (w_shr > POS_LIM) ? FLOW_MAX : FLOW_W'(w_shr);
                end else begin
                    n_held_flow = (w_shr > NEG_LIM) ? FLOW_MIN : FLOW_W'(PROD_W'(0) - w_shr);
                end
                n_held_valid = 1'b1;
                n_state      = S_DIV_C;
            end
            S_DIV_C: begin
                if (!r_issued) begin
                    n_issued = 1'b1;
                end else if (w_div_stat.done) begin
                    n_issued    = 1'b0;
                    n_held_coil = COIL_W'(w_qs);
                    n_state     = S_OUT;
                end
            end
            S_OUT: begin
                // Load the result once the output register is free
                if (!r_out_valid || i_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = OUT_DATA_W'({r_cnt_all, r_held_coil, r_held_flow});
                    n_out_user  = {w_full, r_held_valid};
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control and accumulator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_sum_pos    <= '0;
            r_sum_neg    <= '0;
            r_sum_coil   <= '0;
            r_cnt_pos    <= '0;
            r_cnt_neg    <= '0;
            r_cnt_all    <= '0;
            r_held_flow  <= '0;
            r_held_coil  <= '0;
            r_held_valid <= 1'b0;
            r_issued     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_sum_pos    <= n_sum_pos;
            r_sum_neg    <= n_sum_neg;
            r_sum_coil   <= n_sum_coil;
            r_cnt_pos    <= n_cnt_pos;
            r_cnt_neg    <= n_cnt_neg;
            r_cnt_all    <= n_cnt_all;
            r_held_flow  <= n_held_flow;
            r_held_coil  <= n_held_coil;
            r_held_valid <= n_held_valid;
            r_issued     <= n_issued;
            r_out_valid  <= n_out_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_mean_p   <= n_mean_p;
        r_mean_n   <= n_mean_n;
        r_mag      <= n_mag;
        r_neg      <= n_neg;
        r_prod     <= n_prod;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out_data;
    assign o_tuser  = r_out_user;

    `SDFA_ASSERT(a_count_split, i_clk, i_rst_n, CS_W'(r_cnt_pos) + CS_W'(r_cnt_neg) == CS_W'(r_cnt_all), "half counts do not add up to the total")
    `SDFA_ASSERT(a_invalid_zero, i_clk, i_rst_n, !r_held_valid |-> (r_held_flow == '0), "invalid flow is not zero")
    `SDFA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, r_state == S_OUT && r_out_valid && !i_tready, r_state == S_OUT, "result loaded over a waiting beat")

endmodule

@@ bench/sync_detect_flow_averager_core_test.sv @@
// Self-checking testbench of the synchronous-detection flow averager core.
module sync_detect_flow_averager_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sdfa_pkg::*;

    localparam int SAMPLE_BITS    = 24;
    localparam int COUNT_BITS     = 20;
    localparam int GAIN_FRAC_BITS = 16;
    localparam int OUT_FRAC_BITS  = 8;
    localparam int S_DATA_W       = ((2*SAMPLE_BITS+7)/8)*8;
    localparam int M_DATA_W       = ((FLOW_W+COIL_W+COUNT_BITS+7)/8)*8;
    localparam longint COUNT_MAX  = (longint'(1) << COUNT_BITS) - 1;
    localparam longint CYCLE_LIMIT = 2_000_000;
    localparam int BEATS_PER_PHASE = 310;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int EXTREME_BEATS = 12;

    typedef struct packed {
        logic [FLOW_W-1:0]     flow;
        logic [COIL_W-1:0]     coil;
        logic [COUNT_BITS-1:0] count;
        logic                  valid;
        logic                  full;
    } t_flow_result;

    // Running model of the averager and the queue of results still owed
    class flow_scoreboard;
        logic signed [CFG_W-1:0] zero_offset;
        logic [CFG_W-1:0]        span_gain;
        longint sum_pos, sum_neg, sum_coil;
        longint cnt_pos, cnt_neg, cnt_all;
        longint held_flow, held_coil;
        bit     held_valid;
        t_flow_result expected_q[$];
        int errors;

        function new();
            zero_offset = '0;
            span_gain   = SPAN_GAIN_RESET;
            sum_pos = 0; sum_neg = 0; sum_coil = 0;
            cnt_pos = 0; cnt_neg = 0; cnt_all = 0;
            held_flow = 0; held_coil = 0; held_valid = 0;
            errors = 0;
        endfunction

        function void write_register(logic [CFG_ADDR_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_ZERO_OFFSET: zero_offset = val;
                CFG_SPAN_GAIN:   span_gain   = val;
                default: ;
            endcase
        endfunction

        // Mean with OUT_FRAC_BITS fraction bits, truncated toward zero
        function longint scaled_mean(longint sum, longint cnt);
            return (sum * (longint'(1) << OUT_FRAC_BITS)) / cnt;
        endfunction

        // Apply one accepted beat and queue the result it owes
        function void note_beat(t_action act, logic signed [SAMPLE_BITS-1:0] e,
                                logic signed [SAMPLE_BITS-1:0] c, logic pol);
            longint cal, mp, mn, gain, f;
            t_flow_result res;
            case (act)
                ACT_SAMPLE: begin
                    // drop the sample once the window is full
                    if (cnt_all < COUNT_MAX) begin
                        cal = longint'(e) - longint'(zero_offset);
                        if (pol) begin
                            sum_pos += cal;
                            cnt_pos++;
                        end else begin
                            sum_neg += cal;
                            cnt_neg++;
                        end
                        sum_coil += longint'(c);
                        cnt_all++;
                    end
                end
                ACT_COMPUTE: begin
                    if (cnt_pos == 0 || cnt_neg == 0) begin
                        held_flow  = 0;
                        held_valid = 0;
                    end else begin
                        mp   = scaled_mean(sum_pos, cnt_pos);
                        mn   = scaled_mean(sum_neg, cnt_neg);
                        gain = span_gain;
                        f    = ((mp - mn) * gain) / (longint'(1) << (GAIN_FRAC_BITS + 1));
                        if (f > longint'($signed(FLOW_MAX)))
                            f = longint'($signed(FLOW_MAX));
                        if (f < longint'($signed(FLOW_MIN)))
                            f = longint'($signed(FLOW_MIN));
                        held_flow  = f;
                        held_valid = 1;
                    end
                    held_coil = (cnt_all == 0) ? 0 : scaled_mean(sum_coil, cnt_all);
                end
                ACT_CLEAR: begin
                    sum_pos = 0; sum_neg = 0; sum_coil = 0;
                    cnt_pos = 0; cnt_neg = 0; cnt_all = 0;
                end
                default: ;
            endcase
            res.flow  = held_flow[FLOW_W-1:0];
            res.coil  = held_coil[COIL_W-1:0];
            res.count = cnt_all[COUNT_BITS-1:0];
            res.valid = held_valid;
            res.full  = (cnt_all >= COUNT_MAX);
            expected_q.push_back(res);
        endfunction

        function void compare_field(string name, logic signed [63:0] want,
                                    logic signed [63:0] seen);
            if (seen !== want) begin
                errors++;
                $display("%0t: %s mismatch: expected %0d, actual %0d",
                         $time, name, want, seen);
            end
        endfunction

        // Compare one output beat with the oldest owed result
        function void check_result(t_flow_result got);
            t_flow_result want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, actual %h", $time, got);
                return;
            end
            want = expected_q.pop_front();
            compare_field("flow_signal", $signed(want.flow), $signed(got.flow));
            compare_field("coil_mean", $signed(want.coil), $signed(got.coil));
            compare_field("sample_count", {1'b0, want.count}, {1'b0, got.count});
            compare_field("flow_valid", {1'b0, want.valid}, {1'b0, got.valid});
            compare_field("window_full", {1'b0, want.full}, {1'b0, got.full});
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_W-1:0]      i_cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // electrode, coil_sample
    logic [S_DATA_W-1:0]   s_axis_tdata = '0;
    // action, polarity
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // flow_signal, coil_mean, sample_count
    logic [M_DATA_W-1:0]   m_axis_tdata;
    // flow_valid, window_full
    logic [OUT_USER_W-1:0] m_axis_tuser;

    flow_scoreboard sb = new();
    bit     idle_on = 1'b0;
    bit     long_hold_req = 1'b0;
    longint cycle_count = 0;

    sync_detect_flow_averager_core #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .COUNT_BITS    (COUNT_BITS),
        .GAIN_FRAC_BITS(GAIN_FRAC_BITS),
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Give up after a generous number of cycles
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    // Receive and check result beats; stall in bursts or on a long hold request
    initial begin
        int stall_left;
        int hold_left;
        t_flow_result got;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
                got.flow  = m_axis_tdata[FLOW_W-1:0];
                got.coil  = m_axis_tdata[FLOW_W +: COIL_W];
                got.count = m_axis_tdata[FLOW_W+COIL_W +: COUNT_BITS];
                got.valid = m_axis_tuser[0];
                got.full  = m_axis_tuser[1];
                sb.check_result(got);
            end
            if (long_hold_req) begin
                hold_left = LONG_HOLD_CYCLES;
                long_hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 15) == 0) begin
                stall_left = int'($urandom_range(1, 17)) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Offer one beat and hold it until the block takes it
    task automatic send_beat(input t_action act, input logic [SAMPLE_BITS-1:0] e,
                             input logic [SAMPLE_BITS-1:0] c, input logic pol);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {c, e};
        s_axis_tuser  <= {pol, act};
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        sb.note_beat(act, e, c, pol);
    endtask

    task automatic sender_gap(input int cycles);
        s_axis_tvalid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Stop offering and wait for every owed result
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_q.size() > 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_register(idx, val);
        @(posedge i_clk);
    endtask

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        logic [SAMPLE_BITS-1:0] v;
        case ($urandom_range(0, 9))
            0: v = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            1: v = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            2, 3: begin
                v = SAMPLE_BITS'($urandom_range(0, 1023));
                v = v - SAMPLE_BITS'(512);
            end
            default: v = SAMPLE_BITS'($urandom());
        endcase
        return v;
    endfunction

    // Random mix of actions, mostly samples between clears and computes
    task automatic run_random(input int beats, input bit allow_idle, input int phase);
        int r;
        int pol_bias;
        t_action act;
        logic pol;
        pol_bias = 0;
        for (int i = 0; i < beats; i++) begin
            // alternate stretches with and without idling
            if (i % 60 == 0)
                idle_on = allow_idle && ($urandom_range(0, 3) != 0);
            if (phase == 1 && i == 100)
                long_hold_req = 1'b1;
            if (phase == 2 && i == 150)
                drain();
            if (idle_on && $urandom_range(0, 9) == 0)
                sender_gap(int'($urandom_range(1, 17)));
            r = int'($urandom_range(0, 99));
            if (r < 68)
                act = ACT_SAMPLE;
            else if (r < 82)
                act = ACT_COMPUTE;
            else if (r < 92)
                act = ACT_CLEAR;
            else
                act = ACT_NOP;
            case (pol_bias)
                1: pol = 1'b1;
                2: pol = 1'b0;
                default: pol = 1'($urandom_range(0, 1));
            endcase
            send_beat(act, pick_sample(), pick_sample(), pol);
            // one-sided windows now and then, to hit empty halves
            if (act == ACT_CLEAR)
                pol_bias = int'($urandom_range(0, 4));
        end
    endtask

    // Main sequence
    initial begin
        logic pol;
        logic [CFG_W-1:0] val;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty windows, one-sided windows, extremes, truncation
        idle_on = 1'b1;
        send_beat(ACT_COMPUTE, '0, '0, 1'b0);
        send_beat(ACT_NOP, 24'h7FFFFF, 24'h800000, 1'b1);
        send_beat(ACT_SAMPLE, 24'h7FFFFF, 24'h7FFFFF, 1'b1);
        send_beat(ACT_COMPUTE, '0, '0, 1'b0);
        send_beat(ACT_SAMPLE, 24'h800000, 24'h800000, 1'b0);
        send_beat(ACT_COMPUTE, '0, '0, 1'b1);
        send_beat(ACT_CLEAR, 24'h123456, 24'hABCDEF, 1'b1);
        send_beat(ACT_COMPUTE, '0, '0, 1'b0);
        send_beat(ACT_SAMPLE, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
        send_beat(ACT_SAMPLE, 24'h000001, 24'h000001, 1'b0);
        send_beat(ACT_SAMPLE, 24'h000003, 24'hFFFFFE, 1'b1);
        send_beat(ACT_SAMPLE, 24'hFFFFFE, 24'h000002, 1'b0);
        send_beat(ACT_SAMPLE, 24'h000002, 24'hFFFFFD, 1'b0);
        send_beat(ACT_COMPUTE, '0, '0, 1'b1);
        send_beat(ACT_NOP, '0, '0, 1'b0);
        send_beat(ACT_CLEAR, '0, '0, 1'b0);
        drain();

        // Extreme sums under extreme calibration, giving a large positive flow
        write_reg(CFG_ZERO_OFFSET, 24'h800000);
        write_reg(CFG_SPAN_GAIN, 24'hFFFFFF);
        idle_on = 1'b0;
        for (int n = 0; n < EXTREME_BEATS; n++) begin
            pol = (n % 4 != 0);
            send_beat(ACT_SAMPLE, pol ? 24'h7FFFFF : 24'h800000, 24'h800000, pol);
        end
        send_beat(ACT_COMPUTE, '0, '0, 1'b0);
        send_beat(ACT_SAMPLE, 24'h000010, 24'h000010, 1'b0);
        send_beat(ACT_COMPUTE, '0, '0, 1'b0);
        send_beat(ACT_CLEAR, '0, '0, 1'b0);
        send_beat(ACT_COMPUTE, '0, '0, 1'b0);
        drain();

        // Random phases, each under its own calibration
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_ZERO_OFFSET, '0);
                    write_reg(CFG_SPAN_GAIN, SPAN_GAIN_RESET);
                end
                1: begin
                    write_reg(CFG_ZERO_OFFSET, 24'h7FFFFF);
                    write_reg(CFG_SPAN_GAIN, '0);
                end
                2: begin
                    write_reg(CFG_ZERO_OFFSET, CFG_W'($urandom()));
                    write_reg(CFG_SPAN_GAIN, CFG_W'($urandom()));
                end
                3: begin
                    write_reg(CFG_ZERO_OFFSET, 24'h800000);
                    write_reg(CFG_SPAN_GAIN, 24'hFFFFFF);
                end
                default: begin
                    val = CFG_W'($urandom_range(0, 8191));
                    write_reg(CFG_ZERO_OFFSET, val - CFG_W'(4096));
                    write_reg(CFG_SPAN_GAIN, CFG_W'($urandom_range(0, 24'h020000)));
                end
            endcase
            run_random(BEATS_PER_PHASE, ph != 4, ph);
            drain();
        end

        // Let any stray beat surface before the verdict
        idle_on = 1'b0;
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
